// File: sv/rps_pkg.sv
// rps_pkg: shared types and codes for the round-robin / priority scheduler
// used by rps_cell, rps_chain and rr_priority_cpu_scheduler_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rps_pkg;

   // item kinds on req_type
   localparam logic REQ_ADMIT = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // scheduling modes in the csr
   localparam logic MODE_RR   = 1'b0;
   localparam logic MODE_PRIO = 1'b1;

   typedef struct packed {
      logic [7:0] id;
      logic [1:0] prio;
      logic [7:0] rest;
   } job_type;

   // per-cycle command broadcast to every queue cell
   typedef struct packed {
      logic    admit;
      logic    pop;
      logic    tail_we;
      logic    prio_mode;
      job_type new_job;
      job_type run_job;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// File: sv/rps_cell.sv
// rps_cell: one ready-queue slot, shifts with its neighbors on insert and pop
// depends on rps_pkg
`timescale 1ns / 1ps
`default_nettype none

module rps_cell
   import rps_pkg::*;
(
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire logic         past_len,
   input  wire logic         at_tail,
   input  wire logic         hit_in,
   input  wire job_type      left,
   input  wire job_type      right,
   output job_type           entry,
   output logic              hit_out
);

   job_type entry_ff;
   job_type entry_in;
   logic    hit;

   always_comb begin
      hit      = ctl.prio_mode ? (past_len || (entry_ff.prio > ctl.new_job.prio)) : past_len;
      hit_out  = hit_in || hit;
      entry_in = entry_ff;
      if (ctl.admit) begin
         if (hit_in) begin
            entry_in = left;
         end else if (hit) begin
            entry_in = ctl.new_job;
         end
      end else if (ctl.tail_we && at_tail) begin
         entry_in = ctl.run_job;
      end else if (ctl.pop) begin
         entry_in = right;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// File: sv/rps_chain.sv
// rps_chain: row of rps_cell slots forming the ordered ready queue
// depends on rps_pkg and rps_cell
`timescale 1ns / 1ps
`default_nettype none

module rps_chain
   import rps_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic                               clock,
   input  wire cell_ctl_type                       ctl,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   len,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   tail_idx,
   output job_type                                 head
);

   localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

   job_type entries [QUEUE_DEPTH];
   logic    hits    [QUEUE_DEPTH+1];

   assign hits[0] = 1'b0;

   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      job_type left_w;
      job_type right_w;

      if (k == 0) begin : g_first
         assign left_w = ctl.new_job;
      end else begin : g_mid_l
         assign left_w = entries[k-1];
      end

      if (k == QUEUE_DEPTH - 1) begin : g_last
         assign right_w = entries[k];
      end else begin : g_mid_r
         assign right_w = entries[k+1];
      end

      rps_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .past_len (LEN_W'(k) >= len),
         .at_tail  (LEN_W'(k) == tail_idx),
         .hit_in   (hits[k]),
         .left     (left_w),
         .right    (right_w),
         .entry    (entries[k]),
         .hit_out  (hits[k+1])
      );
   end

   assign head = entries[0];

endmodule

`default_nettype wire

// File: sv/rr_priority_cpu_scheduler_unit.sv
// rr_priority_cpu_scheduler_unit: top level, running slot, queue length and handshake
// depends on rps_pkg and rps_chain
//
// channel  ports                                               direction  transfer when
// req      start busy req_type req_job_id req_job_priority     in         start & !busy
//          req_burst_len
// rsp      rsp_valid rsp_run_id rsp_run_valid rsp_job_done     out        rsp_valid
//          rsp_admit_rejected rsp_ready_count
// csr      csr_wr_en csr_wr_data                               in         csr_wr_en
//
// for each item, the queue cells update at the accepting edge;
// the result strobes in the next cycle while busy is high
// reset clears queue length, running slot, mode and handshake state;
// queue slots are never cleared and are only read below the length
// the receiver cannot stall, so busy lasts exactly one cycle per item
`timescale 1ns / 1ps
`default_nettype none

module rr_priority_cpu_scheduler_unit
   import rps_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_type,
   input  wire logic [7:0] req_job_id,
   input  wire logic [1:0] req_job_priority,
   input  wire logic [7:0] req_burst_len,
   output logic            rsp_valid,
   output logic [7:0]      rsp_run_id,
   output logic            rsp_run_valid,
   output logic            rsp_job_done,
   output logic            rsp_admit_rejected,
   output logic [3:0]      rsp_ready_count,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data
);

   localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

   state_type    state_ff, state_in;
   logic         mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff, len_in;
   job_type      run_ff, run_in;
   logic         run_valid_ff, run_valid_in;

   logic [7:0]   rid_ff, rid_in;
   logic         rvalid_ff, rvalid_in;
   logic         done_ff, done_in;
   logic         rej_ff, rej_in;
   logic [LEN_W-1:0] cnt_ff;

   logic         accept;
   logic         full;
   logic         dispatch;
   logic         active;
   logic         finish;
   logic         requeue;
   logic [LEN_W-1:0] len_pop;
   job_type      head;
   job_type      cur;
   job_type      run_next;
   cell_ctl_type ctl;
   logic [LEN_W+3:0] cnt_ext;

   // handshake state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      busy      = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            busy      = 1'b1;
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign accept = start && !busy;

   // scheduling decisions
   always_comb begin
      full     = (len_ff == LEN_W'(QUEUE_DEPTH));
      dispatch = !run_valid_ff && (len_ff != '0);
      active   = run_valid_ff || dispatch;
      cur      = dispatch ? head : run_ff;
      len_pop  = len_ff - LEN_W'(dispatch);
      finish   = active && (cur.rest <= 8'd1);
      requeue  = active && !finish && (mode_ff == MODE_RR)
                 && (len_pop != LEN_W'(QUEUE_DEPTH));
      run_next.id   = cur.id;
      run_next.prio = cur.prio;
      run_next.rest = finish ? 8'd0 : (cur.rest - 8'd1);

      ctl.admit     = accept && (req_type == REQ_ADMIT) && !full;
      ctl.pop       = accept && (req_type == REQ_TICK) && dispatch;
      ctl.tail_we   = accept && (req_type == REQ_TICK) && requeue;
      ctl.prio_mode = (mode_ff == MODE_PRIO);
      ctl.new_job.id   = req_job_id;
      ctl.new_job.prio = req_job_priority;
      ctl.new_job.rest = req_burst_len;
      ctl.run_job   = run_next;

      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      len_in       = len_ff;
      run_in       = run_ff;
      run_valid_in = run_valid_ff;
      rid_in       = rid_ff;
      rvalid_in    = rvalid_ff;
      done_in      = done_ff;
      rej_in       = rej_ff;

      if (accept) begin
         if (req_type == REQ_ADMIT) begin
            rid_in    = 8'd0;
            rvalid_in = 1'b0;
            done_in   = 1'b0;
            rej_in    = full;
            if (!full) begin
               len_in = len_ff + LEN_W'(1);
            end
         end else begin
            rid_in    = active ? cur.id : 8'd0;
            rvalid_in = active;
            done_in   = finish;
            rej_in    = 1'b0;
            if (active) begin
               run_in       = run_next;
               run_valid_in = !finish && !requeue;
               len_in       = len_pop + LEN_W'(requeue);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RR;
         len_ff       <= '0;
         run_ff       <= '0;
         run_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         len_ff       <= len_in;
         run_ff       <= run_in;
         run_valid_ff <= run_valid_in;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      rid_ff    <= rid_in;
      rvalid_ff <= rvalid_in;
      done_ff   <= done_in;
      rej_ff    <= rej_in;
      if (accept) begin
         cnt_ff <= len_in;
      end
   end

   rps_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_chain (
      .clock    (clock),
      .ctl      (ctl),
      .len      (len_ff),
      .tail_idx (len_pop),
      .head     (head)
   );

   assign cnt_ext            = {4'd0, cnt_ff};
   assign rsp_run_id         = rid_ff;
   assign rsp_run_valid      = rvalid_ff;
   assign rsp_job_done       = done_ff;
   assign rsp_admit_rejected = rej_ff;
   assign rsp_ready_count    = cnt_ext[3:0];

endmodule

`default_nettype wire
